FILE: hw/rtl/quintic_trajectory_generator_top_macros.svh
// Assertion macros for the trajectory generator RTL.
`ifndef QUINTIC_TRAJECTORY_GENERATOR_TOP_MACROS_SVH
`define QUINTIC_TRAJECTORY_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define QTG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QTG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define QTG_ASSERT(lbl, clk, rst_n, prop, msg)
`define QTG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/qtg_pkg.sv
`timescale 1ns / 1ps
package qtg_pkg;

  localparam int unsigned DivBits = 80;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_RETARGET = 2'd1;
  localparam logic [1:0] OP_EVAL     = 2'd2;
  localparam logic [1:0] OP_RESTART  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DUR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [2:0] CFG_START_POS = 3'd0;
  localparam logic [2:0] CFG_START_SPD = 3'd1;
  localparam logic [2:0] CFG_START_ACC = 3'd2;
  localparam logic [2:0] CFG_GOAL_POS  = 3'd3;
  localparam logic [2:0] CFG_GOAL_SPD  = 3'd4;
  localparam logic [2:0] CFG_GOAL_ACC  = 3'd5;
  localparam logic [2:0] CFG_DURATION  = 3'd6;
  localparam logic [2:0] CFG_TICK      = 3'd7;

  localparam logic [31:0] CFG_DURATION_RST = 32'd65536;
  localparam logic [31:0] CFG_TICK_RST     = 32'd66;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] new_position;
    logic signed [31:0] new_speed;
    logic signed [31:0] new_accel;
    logic [31:0]        new_duration;
    logic [31:0]        eval_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic               advanced;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] x;
    logic [32:0]        s;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DivBits-1:0] num;
    logic [31:0]        den;
  } div_req_t;

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x[63] ? (64'd0 - $unsigned(x)) : $unsigned(x);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    logic signed [63:0] r;
    if (!neg) begin
      r = m[63] ? S64_MAX : $signed(m);
    end else if (m[63]) begin
      r = S64_MIN;
    end else begin
      r = -$signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sneg(input logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  // Saturating multiply by a small signed constant; negation comes first.
  function automatic logic signed [63:0] smul_k(input logic signed [63:0] a,
                                                input logic signed [5:0] k);
    logic signed [63:0] aa;
    logic [4:0]         kk;
    logic signed [69:0] p;
    aa = k[5] ? sneg(a) : a;
    kk = k[5] ? 5'(-k) : k[4:0];
    p  = aa * $signed({1'b0, kk});
    if (p[69:63] != {7{p[69]}}) begin
      return p[69] ? S64_MIN : S64_MAX;
    end
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] half(input logic signed [63:0] x);
    logic [64:0] t;
    t = {1'b0, mag(x)} + 65'd1;
    return from_mag(x[63], t[64:1]);
  endfunction

  function automatic logic clamp_hit(input logic signed [63:0] x);
    return x[63:31] != {33{x[63]}};
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
    if (clamp_hit(x)) begin
      return x[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return x[31:0];
  endfunction

  // Weights of dp, Vf, V0, A0, Af for the three upper coefficients.
  function automatic logic signed [5:0] coef_k(input logic [1:0] row, input logic [2:0] term);
    logic signed [5:0] k;
    case ({row, term})
      5'b00_000: k = 6'sd20;
      5'b00_001: k = -6'sd8;
      5'b00_010: k = -6'sd12;
      5'b00_011: k = -6'sd3;
      5'b00_100: k = 6'sd1;
      5'b01_000: k = -6'sd30;
      5'b01_001: k = 6'sd14;
      5'b01_010: k = 6'sd16;
      5'b01_011: k = 6'sd3;
      5'b01_100: k = -6'sd2;
      5'b10_000: k = 6'sd12;
      5'b10_001: k = -6'sd6;
      5'b10_010: k = -6'sd6;
      5'b10_011: k = -6'sd1;
      5'b10_100: k = 6'sd1;
      default:   k = 6'sd0;
    endcase
    return k;
  endfunction

  // Derivative weight of coefficient i for pass 0 (value), 1 (first), 2 (second).
  function automatic logic signed [5:0] horner_k(input logic [1:0] pass, input logic [2:0] i);
    logic signed [5:0] k;
    case (pass)
      2'd0: k = 6'sd1;
      2'd1: k = $signed({3'd0, i});
      2'd2: begin
        case (i)
          3'd2:    k = 6'sd2;
          3'd3:    k = 6'sd6;
          3'd4:    k = 6'sd12;
          3'd5:    k = 6'sd20;
          default: k = 6'sd0;
        endcase
      end
      default: k = 6'sd0;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/qtg_mulq.sv
`timescale 1ns / 1ps
// Computes round(x * s / 2^32) on magnitudes with one 32x33 multiplier.
module qtg_mulq import qtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_req_t           req_i,
  output logic               done_o,
  output logic signed [63:0] y_o
);

  logic [1:0]  phase_q;
  logic        busy_q;
  logic        done_q;
  logic        neg_q;
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  logic [32:0] s_q;
  logic [64:0] plo_q;
  logic [64:0] phi_q;
  logic [63:0] m;
  logic [31:0] opa;
  logic [64:0] prod;
  logic [65:0] r;
  logic signed [63:0] y_q;

  assign m    = mag(req_i.x);
  assign opa  = (phase_q == 2'd0) ? lo_q : hi_q;
  assign prod = {33'd0, opa} * {32'd0, s_q};
  assign r    = {1'b0, phi_q} + {33'd0, 33'((plo_q + 65'h8000_0000) >> 32)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      neg_q   <= 1'b0;
      hi_q    <= '0;
      lo_q    <= '0;
      s_q     <= '0;
      plo_q   <= '0;
      phi_q   <= '0;
      y_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= 2'd0;
        neg_q   <= req_i.x[63];
        hi_q    <= m[63:32];
        lo_q    <= m[31:0];
        s_q     <= req_i.s;
      end else if (busy_q) begin
        case (phase_q)
          2'd0: begin
            plo_q   <= prod;
            phase_q <= 2'd1;
          end
          2'd1: begin
            phi_q   <= prod;
            phase_q <= 2'd2;
          end
          default: begin
            y_q     <= from_mag(neg_q, (r[65:64] != 2'd0) ? '1 : r[63:0]);
            done_q  <= 1'b1;
            busy_q  <= 1'b0;
            phase_q <= 2'd0;
          end
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

FILE: hw/rtl/qtg_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The quotient is capped at 2^63.
module qtg_div import qtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivBits);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivBits-1:0] num_q;
  logic [31:0]        den_q;
  logic [31:0]        rem_q;
  logic [32:0]        rem_sh;
  logic               ge;
  logic [32:0]        rem_sub;

  assign rem_sh  = {rem_q, num_q[DivBits-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= req_i.num;
        den_q  <= req_i.den;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
        num_q <= {num_q[DivBits-2:0], ge};
        if (cnt_q == CntW'(DivBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = (|num_q[DivBits-1:63]) ? {1'b1, 63'd0} : num_q[63:0];

endmodule

FILE: hw/rtl/quintic_trajectory_generator_top.sv
`timescale 1ns / 1ps
// Quintic trajectory generator: signed Q16.16 values, unsigned Q16.16 times.
// Input channel (in_valid_i / in_stall_o / in_data_i): one item per operation:
// tick, retarget, evaluate at a given time, or restart from the configuration.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one item per
// input item, carrying the current position, speed, acceleration, the advanced
// flag and a status code.
// Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): eight
// 32-bit registers, always ready; write them only while the block is idle.
// One item is worked on at a time and in_stall_o is high until its result is
// registered; the next item can be accepted in the following cycle.
// Restart and retarget: six multiplies on the shared multiplier, fifteen add
// steps and one output step. Tick and evaluate: four divisions on the bit-serial
// divider, twelve Horner multiply steps, three pass starts, clamp and output.
// Items that compute nothing go straight to the output step.
// A finished item waits in the output register while out_stall_i is high; the
// next item is accepted meanwhile, and its result is held back until the
// register is free. Reset clears the segment, the state and the output, and
// loads the configuration defaults (duration 1.0 s, tick 66 LSB).
`include "quintic_trajectory_generator_top_macros.svh"
module quintic_trajectory_generator_top import qtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_BMUL_GO   = 4'd1;
  localparam logic [3:0] S_BMUL_WAIT = 4'd2;
  localparam logic [3:0] S_BLIN      = 4'd3;
  localparam logic [3:0] S_DIV_GO    = 4'd4;
  localparam logic [3:0] S_DIV_WAIT  = 4'd5;
  localparam logic [3:0] S_HINIT     = 4'd6;
  localparam logic [3:0] S_HMUL_GO   = 4'd7;
  localparam logic [3:0] S_HMUL_WAIT = 4'd8;
  localparam logic [3:0] S_CLAMP     = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0]         state_q;
  logic [2:0]         j_q;
  logic [1:0]         row_q;
  logic [2:0]         term_q;
  logic [1:0]         pass_q;

  logic [31:0]        cfg_q [8];
  logic signed [63:0] coef_q [6];
  logic [31:0]        elapsed_q;
  logic [31:0]        dur_q;
  logic signed [31:0] pos_q;
  logic signed [31:0] spd_q;
  logic signed [31:0] acc_q;

  logic signed [31:0] b_p0_q, b_v0_q, b_a0_q, b_pf_q, b_vf_q, b_af_q;
  logic [31:0]        b_t_q;
  logic               restart_q;
  logic signed [63:0] v0t_q, vft_q, a0t_q, aft_q;

  logic [31:0]        t_q;
  logic [32:0]        s_q;
  logic signed [63:0] hacc_q;
  logic signed [63:0] hp_q, hd_q, hdd_q;
  logic signed [63:0] spd_full_q, acc_full_q;

  logic               adv_q;
  logic [1:0]         status_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               in_acc;
  logic               out_free;
  logic [32:0]        nt;
  logic               tick_ok;
  logic               eval_ok;
  logic signed [63:0] dp_b;
  logic [2:0]         cidx;
  logic signed [63:0] coef_rd;
  logic signed [63:0] ka_base;
  logic signed [63:0] ka_opnd;
  logic signed [5:0]  ka_k;
  logic signed [63:0] ka_out;
  logic signed [63:0] div_x;
  logic [79:0]        half_dur;

  mul_req_t           mul_req;
  logic               mul_done;
  logic signed [63:0] mul_y;
  div_req_t           div_req;
  logic               div_done;
  logic [63:0]        div_quot;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign nt          = {1'b0, elapsed_q} + {1'b0, cfg_q[CFG_TICK]};
  assign tick_ok     = (dur_q != '0) && (nt <= {1'b0, dur_q});
  assign eval_ok     = (dur_q != '0) && (in_data_i.eval_time <= dur_q);
  assign dp_b        = 64'(b_pf_q) - 64'(b_p0_q);
  assign cidx        = (state_q == S_HINIT) ? 3'd5 : j_q;
  assign coef_rd     = coef_q[cidx];
  assign ka_out      = sadd(ka_base, smul_k(ka_opnd, ka_k));
  assign half_dur    = {48'd0, 1'b0, dur_q[31:1]};

  // Shared saturating multiply-by-constant and add.
  always_comb begin
    ka_base = '0;
    ka_opnd = coef_rd;
    ka_k    = horner_k(pass_q, j_q);
    case (state_q)
      S_HINIT: ka_k = horner_k(pass_q, 3'd5);
      S_HMUL_WAIT: ka_base = mul_y;
      S_BLIN: begin
        ka_base = (term_q == 3'd0) ? '0 : hacc_q;
        ka_k    = coef_k(row_q, term_q);
        case (term_q)
          3'd0:    ka_opnd = dp_b;
          3'd1:    ka_opnd = vft_q;
          3'd2:    ka_opnd = v0t_q;
          3'd3:    ka_opnd = a0t_q;
          default: ka_opnd = aft_q;
        endcase
      end
      default: ;
    endcase
  end

  // Multiplier jobs. Scaling by 2^16 or 2^32 turns v*T and a*T*T into rounded products.
  always_comb begin
    mul_req.start = (state_q == S_BMUL_GO) || (state_q == S_HMUL_GO);
    mul_req.s     = {1'b0, b_t_q};
    mul_req.x     = hacc_q;
    if (state_q != S_HMUL_GO) begin
      case (j_q)
        3'd0:    mul_req.x = 64'(b_v0_q) <<< 16;
        3'd1:    mul_req.x = 64'(b_vf_q) <<< 16;
        3'd2:    mul_req.x = 64'(b_a0_q) <<< 32;
        3'd3:    mul_req.x = a0t_q;
        3'd4:    mul_req.x = 64'(b_af_q) <<< 32;
        default: mul_req.x = aft_q;
      endcase
    end else begin
      mul_req.s = s_q;
    end
  end

  // Divider jobs: normalized time first, then the rounded divisions by T.
  always_comb begin
    case (j_q)
      3'd1:    div_x = hd_q;
      3'd2:    div_x = hdd_q;
      default: div_x = acc_full_q;
    endcase
    div_req.start = (state_q == S_DIV_GO);
    div_req.den   = dur_q;
    if (j_q == 3'd0) begin
      div_req.num = {16'd0, t_q, 32'd0} + half_dur;
    end else begin
      div_req.num = {mag(div_x), 16'd0} + half_dur;
    end
  end

  qtg_mulq u_mulq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .y_o    (mul_y)
  );

  qtg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      j_q         <= '0;
      row_q       <= '0;
      term_q      <= '0;
      pass_q      <= '0;
      for (int i = 0; i < 8; i++) begin
        cfg_q[i] <= '0;
      end
      cfg_q[CFG_DURATION] <= CFG_DURATION_RST;
      cfg_q[CFG_TICK]     <= CFG_TICK_RST;
      for (int i = 0; i < 6; i++) begin
        coef_q[i] <= '0;
      end
      elapsed_q   <= '0;
      dur_q       <= '0;
      pos_q       <= '0;
      spd_q       <= '0;
      acc_q       <= '0;
      b_p0_q      <= '0;
      b_v0_q      <= '0;
      b_a0_q      <= '0;
      b_pf_q      <= '0;
      b_vf_q      <= '0;
      b_af_q      <= '0;
      b_t_q       <= '0;
      restart_q   <= 1'b0;
      v0t_q       <= '0;
      vft_q       <= '0;
      a0t_q       <= '0;
      aft_q       <= '0;
      t_q         <= '0;
      s_q         <= '0;
      hacc_q      <= '0;
      hp_q        <= '0;
      hd_q        <= '0;
      hdd_q       <= '0;
      spd_full_q  <= '0;
      acc_full_q  <= '0;
      adv_q       <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            adv_q    <= 1'b0;
            status_q <= ST_OK;
            j_q      <= '0;
            pass_q   <= '0;
            row_q    <= '0;
            term_q   <= '0;
            state_q  <= S_OUT;
            case (in_data_i.operation)
              OP_RESTART: begin
                if (cfg_q[CFG_DURATION] == '0) begin
                  status_q <= ST_ZERO_DUR;
                end else begin
                  b_p0_q    <= cfg_q[CFG_START_POS];
                  b_v0_q    <= cfg_q[CFG_START_SPD];
                  b_a0_q    <= cfg_q[CFG_START_ACC];
                  b_pf_q    <= cfg_q[CFG_GOAL_POS];
                  b_vf_q    <= cfg_q[CFG_GOAL_SPD];
                  b_af_q    <= cfg_q[CFG_GOAL_ACC];
                  b_t_q     <= cfg_q[CFG_DURATION];
                  restart_q <= 1'b1;
                  state_q   <= S_BMUL_GO;
                end
              end
              OP_RETARGET: begin
                if (in_data_i.new_duration == '0) begin
                  status_q <= ST_ZERO_DUR;
                end else begin
                  b_p0_q    <= pos_q;
                  b_v0_q    <= spd_q;
                  b_a0_q    <= acc_q;
                  b_pf_q    <= in_data_i.new_position;
                  b_vf_q    <= in_data_i.new_speed;
                  b_af_q    <= in_data_i.new_accel;
                  b_t_q     <= in_data_i.new_duration;
                  restart_q <= 1'b0;
                  state_q   <= S_BMUL_GO;
                end
              end
              OP_TICK: begin
                if (tick_ok) begin
                  elapsed_q <= nt[31:0];
                  t_q       <= nt[31:0];
                  state_q   <= S_DIV_GO;
                end
              end
              OP_EVAL: begin
                if (eval_ok) begin
                  t_q     <= in_data_i.eval_time;
                  state_q <= S_DIV_GO;
                end
              end
              default: ;
            endcase
          end
        end

        S_BMUL_GO: state_q <= S_BMUL_WAIT;

        S_BMUL_WAIT: begin
          if (mul_done) begin
            case (j_q)
              3'd0:      v0t_q <= mul_y;
              3'd1:      vft_q <= mul_y;
              3'd2, 3'd3: a0t_q <= mul_y;
              default:   aft_q <= mul_y;
            endcase
            if (j_q == 3'd5) begin
              state_q <= S_BLIN;
            end else begin
              j_q     <= j_q + 3'd1;
              state_q <= S_BMUL_GO;
            end
          end
        end

        // One weighted term per cycle for c3, c4 and c5.
        S_BLIN: begin
          hacc_q <= ka_out;
          if (row_q == 2'd0 && term_q == 3'd0) begin
            coef_q[0] <= 64'(b_p0_q);
            coef_q[1] <= v0t_q;
            coef_q[2] <= half(a0t_q);
          end
          if (term_q == 3'd4) begin
            coef_q[3'd3 + 3'(row_q)] <= half(ka_out);
            term_q <= '0;
            if (row_q == 2'd2) begin
              elapsed_q <= '0;
              dur_q     <= b_t_q;
              if (restart_q) begin
                pos_q <= b_p0_q;
                spd_q <= b_v0_q;
                acc_q <= b_a0_q;
              end
              state_q <= S_OUT;
            end else begin
              row_q <= row_q + 2'd1;
            end
          end else begin
            term_q <= term_q + 3'd1;
          end
        end

        S_DIV_GO: state_q <= S_DIV_WAIT;

        S_DIV_WAIT: begin
          if (div_done) begin
            case (j_q)
              3'd0:    s_q <= div_quot[32:0];
              3'd1:    spd_full_q <= from_mag(hd_q[63], div_quot);
              3'd2:    acc_full_q <= from_mag(hdd_q[63], div_quot);
              default: acc_full_q <= from_mag(acc_full_q[63], div_quot);
            endcase
            if (j_q == 3'd0) begin
              pass_q  <= '0;
              state_q <= S_HINIT;
            end else if (j_q == 3'd3) begin
              state_q <= S_CLAMP;
            end else begin
              j_q     <= j_q + 3'd1;
              state_q <= S_DIV_GO;
            end
          end
        end

        // Horner passes for the value, the first and the second derivative.
        S_HINIT: begin
          hacc_q  <= ka_out;
          j_q     <= 3'd4;
          state_q <= S_HMUL_GO;
        end

        S_HMUL_GO: state_q <= S_HMUL_WAIT;

        S_HMUL_WAIT: begin
          if (mul_done) begin
            hacc_q <= ka_out;
            if (j_q == {1'b0, pass_q}) begin
              case (pass_q)
                2'd0:    hp_q <= ka_out;
                2'd1:    hd_q <= ka_out;
                default: hdd_q <= ka_out;
              endcase
              if (pass_q == 2'd2) begin
                j_q     <= 3'd1;
                state_q <= S_DIV_GO;
              end else begin
                pass_q  <= pass_q + 2'd1;
                state_q <= S_HINIT;
              end
            end else begin
              j_q     <= j_q - 3'd1;
              state_q <= S_HMUL_GO;
            end
          end
        end

        S_CLAMP: begin
          pos_q    <= clamp32(hp_q);
          spd_q    <= clamp32(spd_full_q);
          acc_q    <= clamp32(acc_full_q);
          adv_q    <= 1'b1;
          status_q <= (clamp_hit(hp_q) || clamp_hit(spd_full_q) || clamp_hit(acc_full_q))
                      ? ST_SAT : ST_OK;
          state_q  <= S_OUT;
        end

        S_OUT: begin
          if (out_free) begin
            out_q.position <= pos_q;
            out_q.speed    <= spd_q;
            out_q.accel    <= acc_q;
            out_q.advanced <= adv_q;
            out_q.status   <= status_q;
            out_valid_q    <= 1'b1;
            state_q        <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `QTG_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_acc |=> state_q != S_IDLE, "accepted item did not start")
  `QTG_ASSERT(a_out_from_seq, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == S_OUT, "result outside output step")
  `QTG_ASSERT(a_mul_done_wait, clk_i, rst_ni, mul_done |-> state_q == S_BMUL_WAIT || state_q == S_HMUL_WAIT, "stray multiplier result")
  `QTG_ASSERT(a_div_done_wait, clk_i, rst_ni, div_done |-> state_q == S_DIV_WAIT, "stray divider result")
  `QTG_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> state_q == S_IDLE && !out_valid_q, "reset did not clear control")

endmodule

FILE: tb/sv/quintic_trajectory_generator_checker.sv
`timescale 1ns / 1ps
module quintic_trajectory_generator_checker import qtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic signed [63:0] Max64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Min64 = 64'sh8000_0000_0000_0000;

  logic [31:0]        regs [8];
  logic signed [63:0] coef [6];
  logic [31:0]        elapsed;
  logic [31:0]        seg_dur;
  logic signed [63:0] cur_pos, cur_spd, cur_acc;
  out_item_t          expected_q[$];

  function automatic logic [63:0] abs64(logic signed [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic signed [63:0] signed_of(logic neg, logic [63:0] m);
    if (!neg) return m[63] ? Max64 : $signed(m);
    if (m[63]) return Min64;
    return -$signed(m);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? Min64 : Max64;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] neg_sat(logic signed [63:0] a);
    return (a == Min64) ? Max64 : -a;
  endfunction

  function automatic logic signed [63:0] scale_sat(logic signed [63:0] a, int k);
    logic signed [127:0] aw, kw, p;
    if (k < 0) begin
      a = neg_sat(a);
      k = -k;
    end
    aw = a;
    kw = k;
    p = aw * kw;
    if (p[127:63] != {65{p[127]}}) return p[127] ? Min64 : Max64;
    return p[63:0];
  endfunction

  // Rounded x*s/2^32 for a normalized time s of at most 1.0 in Q1.32.
  function automatic logic signed [63:0] frac_mul(logic signed [63:0] x, logic [32:0] s);
    logic [127:0] m, hi, lo, r;
    m = abs64(x);
    hi = m >> 32;
    lo = m[31:0];
    r = hi * s + ((lo * s + 128'h8000_0000) >> 32);
    return signed_of(x[63], r[63:0]);
  endfunction

  // Rounded x*2^16/t, that is x divided by a Q16.16 duration.
  function automatic logic signed [63:0] per_dur(logic signed [63:0] x, logic [31:0] t);
    logic [63:0] m, q, r, tt;
    tt = t;
    m = abs64(x);
    q = m / tt;
    r = m % tt;
    if (q >= (64'd1 << 47)) return signed_of(x[63], 64'h8000_0000_0000_0000);
    return signed_of(x[63], (q << 16) + (((r << 16) + tt / 2) / tt));
  endfunction

  function automatic logic signed [63:0] halve(logic signed [63:0] x);
    return signed_of(x[63], (abs64(x) + 64'd1) >> 1);
  endfunction

  function automatic logic signed [63:0] by_dur(logic signed [63:0] v, logic [31:0] t);
    logic [127:0] p;
    p = abs64(v) * t;
    return signed_of(v[63], 64'((p + 128'h8000) >> 16));
  endfunction

  function automatic logic signed [63:0] by_dur_sq(logic signed [63:0] a, logic [31:0] t);
    logic [127:0] p;
    p = abs64(a) * t;
    return frac_mul(signed_of(a[63], p[63:0]), {1'b0, t});
  endfunction

  task automatic build_segment(logic signed [63:0] p0, v0, a0, pf, vf, af, logic [31:0] t);
    logic signed [63:0] dp, sv0, svf, sa0, saf, x;
    dp = pf - p0;
    sv0 = by_dur(v0, t);
    svf = by_dur(vf, t);
    sa0 = by_dur_sq(a0, t);
    saf = by_dur_sq(af, t);
    coef[0] = p0;
    coef[1] = sv0;
    coef[2] = halve(sa0);
    x = scale_sat(dp, 20);
    x = add_sat(x, scale_sat(svf, -8));
    x = add_sat(x, scale_sat(sv0, -12));
    x = add_sat(x, scale_sat(sa0, -3));
    x = add_sat(x, saf);
    coef[3] = halve(x);
    x = scale_sat(dp, -30);
    x = add_sat(x, scale_sat(svf, 14));
    x = add_sat(x, scale_sat(sv0, 16));
    x = add_sat(x, scale_sat(sa0, 3));
    x = add_sat(x, scale_sat(saf, -2));
    coef[4] = halve(x);
    x = scale_sat(dp, 12);
    x = add_sat(x, scale_sat(svf, -6));
    x = add_sat(x, scale_sat(sv0, -6));
    x = add_sat(x, neg_sat(sa0));
    x = add_sat(x, saf);
    coef[5] = halve(x);
  endtask

  function automatic logic signed [63:0] clip32(logic signed [63:0] v, inout logic hit);
    if (v > 64'sh7FFF_FFFF) begin
      hit = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      hit = 1'b1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  task automatic sample_point(logic [31:0] t, output logic [1:0] st);
    logic [63:0]        d, s;
    logic signed [63:0] p, dv, d2;
    logic               hit;
    d = seg_dur;
    s = ({t, 32'd0} + d / 2) / d;
    p = coef[5];
    dv = scale_sat(coef[5], 5);
    d2 = scale_sat(coef[5], 20);
    hit = 1'b0;
    for (int i = 4; i >= 0; i--) p = add_sat(frac_mul(p, s[32:0]), coef[i]);
    for (int i = 4; i >= 1; i--) dv = add_sat(frac_mul(dv, s[32:0]), scale_sat(coef[i], i));
    for (int i = 4; i >= 2; i--)
      d2 = add_sat(frac_mul(d2, s[32:0]), scale_sat(coef[i], i * (i - 1)));
    cur_pos = clip32(p, hit);
    cur_spd = clip32(per_dur(dv, seg_dur), hit);
    cur_acc = clip32(per_dur(per_dur(d2, seg_dur), seg_dur), hit);
    st = hit ? ST_SAT : ST_OK;
  endtask

  task automatic predict_item(in_item_t it, output out_item_t r);
    logic [1:0]  st;
    logic        adv;
    logic [32:0] nt;
    st = ST_OK;
    adv = 1'b0;
    case (it.operation)
      OP_RESTART: begin
        if (regs[CFG_DURATION] == 0) begin
          st = ST_ZERO_DUR;
        end else begin
          build_segment($signed(regs[CFG_START_POS]), $signed(regs[CFG_START_SPD]),
                        $signed(regs[CFG_START_ACC]), $signed(regs[CFG_GOAL_POS]),
                        $signed(regs[CFG_GOAL_SPD]), $signed(regs[CFG_GOAL_ACC]),
                        regs[CFG_DURATION]);
          elapsed = 0;
          seg_dur = regs[CFG_DURATION];
          cur_pos = $signed(regs[CFG_START_POS]);
          cur_spd = $signed(regs[CFG_START_SPD]);
          cur_acc = $signed(regs[CFG_START_ACC]);
        end
      end
      OP_RETARGET: begin
        if (it.new_duration == 0) begin
          st = ST_ZERO_DUR;
        end else begin
          build_segment(cur_pos, cur_spd, cur_acc, it.new_position, it.new_speed,
                        it.new_accel, it.new_duration);
          elapsed = 0;
          seg_dur = it.new_duration;
        end
      end
      OP_TICK: begin
        nt = elapsed + regs[CFG_TICK];
        if (seg_dur != 0 && nt <= seg_dur) begin
          elapsed = nt[31:0];
          sample_point(nt[31:0], st);
          adv = 1'b1;
        end
      end
      default: begin
        if (seg_dur != 0 && it.eval_time <= seg_dur) begin
          sample_point(it.eval_time, st);
          adv = 1'b1;
        end
      end
    endcase
    r.position = cur_pos[31:0];
    r.speed = cur_spd[31:0];
    r.accel = cur_acc[31:0];
    r.advanced = adv;
    r.status = st;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    out_item_t r;
    if (!rst_ni) begin
      foreach (regs[i]) regs[i] = '0;
      regs[CFG_DURATION] = CFG_DURATION_RST;
      regs[CFG_TICK] = CFG_TICK_RST;
      foreach (coef[i]) coef[i] = '0;
      elapsed = '0;
      seg_dur = '0;
      cur_pos = '0;
      cur_spd = '0;
      cur_acc = '0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_data_i !== e) begin
            fail_count_o <= fail_count_o + 1;
            if (out_data_i.position !== e.position)
              $error("position exp %0d got %0d", e.position, out_data_i.position);
            if (out_data_i.speed !== e.speed)
              $error("speed exp %0d got %0d", e.speed, out_data_i.speed);
            if (out_data_i.accel !== e.accel)
              $error("accel exp %0d got %0d", e.accel, out_data_i.accel);
            if (out_data_i.advanced !== e.advanced)
              $error("advanced exp %0d got %0d", e.advanced, out_data_i.advanced);
            if (out_data_i.status !== e.status)
              $error("status exp %0d got %0d", e.status, out_data_i.status);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_item(in_data_i, r);
        expected_q.push_back(r);
      end
      if (cfg_valid_i && cfg_ready_i) regs[cfg_index_i] = cfg_data_i;
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: tb/sv/quintic_trajectory_generator_top_tb.sv
`timescale 1ns / 1ps
module quintic_trajectory_generator_top_tb;
  import qtg_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;
  logic [31:0] seg_dur_seen = '0;
  logic [31:0] restart_dur = CFG_DURATION_RST;

  always #6 clk_i = ~clk_i;

  quintic_trajectory_generator_top uut (.*);

  quintic_trajectory_generator_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Any handshake counts as progress; a long silence means the block hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4, 0))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 ** 20, 0)) - 2 ** 19);
      2: return 32'($signed($urandom_range(2 ** 18, 0)) - 2 ** 17);
      3: begin
        case ($urandom_range(4, 0))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return 32'd1;
          default: return 32'd0;
        endcase
      end
      default: return 32'($signed($urandom_range(2 ** 24, 0)) - 2 ** 23);
    endcase
  endfunction

  function automatic logic [31:0] pick_duration();
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      default: return $urandom_range(32'h4_0000, 1);
    endcase
  endfunction

  // Both edges bracket the sample so the stall value is stable when read.
  task automatic send_item(in_item_t it);
    logic stalled;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    if (it.operation == OP_RESTART && restart_dur != 0) seg_dur_seen = restart_dur;
    if (it.operation == OP_RETARGET && it.new_duration != 0) seg_dur_seen = it.new_duration;
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic ready;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      ready = cfg_ready_o;
      @(posedge clk_i);
    end while (!ready);
    if (idx == CFG_DURATION) restart_dur = val;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] vals [8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), vals[i]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [31:0] p, v, a, d, t);
    in_item_t it;
    it.operation = op;
    it.new_position = p;
    it.new_speed = v;
    it.new_accel = a;
    it.new_duration = d;
    it.eval_time = t;
    return it;
  endfunction

  task automatic random_item();
    in_item_t    it;
    int          r;
    logic [31:0] t;
    r = $urandom_range(99, 0);
    t = (seg_dur_seen == 0) ? $urandom() : $urandom_range(seg_dur_seen, 0);
    if ($urandom_range(9, 0) == 0) t = $urandom();
    it = make_item(OP_TICK, pick_value(), pick_value(), pick_value(), pick_duration(), t);
    if (r < 8) it.operation = OP_RESTART;
    else if (r < 20) it.operation = OP_RETARGET;
    else if (r < 45) it.operation = OP_EVAL;
    send_item(it);
  endtask

  initial begin
    logic [31:0] vals [8];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing to evaluate before the first segment exists; a restart then builds one.
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 0));
    send_item(make_item(OP_RESTART, 0, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'd65536));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'd65537));
    send_item(make_item(OP_RETARGET, 32'h7FFF_FFFF, 0, 0, 32'd0, 0));
    send_item(make_item(OP_RETARGET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'h8000_0000));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    send_item(make_item(OP_RETARGET, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'd1));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'd2));
    settle();
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
    write_all(vals);
    // A restart with zero duration is rejected and keeps the old segment.
    send_item(make_item(OP_RESTART, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'd1));
    settle();
    vals[CFG_DURATION] = 32'hFFFF_FFFF;
    write_all(vals);
    send_item(make_item(OP_RESTART, 0, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 0));
    send_item(make_item(OP_EVAL, 0, 0, 0, 0, 32'h7FFF_FFFF));
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int i = 0; i < 6; i++) vals[i] = pick_value();
      vals[CFG_DURATION] = $urandom_range(32'h2_0000, 1);
      vals[CFG_TICK] = vals[CFG_DURATION] / $urandom_range(40, 3);
      if (phase == 2) begin
        vals[CFG_DURATION] = 32'd1;
        vals[CFG_TICK] = 32'd0;
      end
      write_all(vals);
      for (int n = 0; n < 320; n++) begin
        random_item();
        // Rewrite the registers now and then, always from an idle block.
        if (n % 80 == 79) begin
          settle();
          for (int i = 0; i < 6; i++) vals[i] = pick_value();
          vals[CFG_DURATION] = pick_duration();
          vals[CFG_TICK] = (vals[CFG_DURATION] == 0) ? $urandom_range(1000, 0) :
                           vals[CFG_DURATION] / $urandom_range(50, 2);
          write_all(vals);
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/qtg_pkg.sv
hw/rtl/qtg_mulq.sv
hw/rtl/qtg_div.sv
hw/rtl/quintic_trajectory_generator_top.sv
tb/sv/quintic_trajectory_generator_checker.sv
tb/sv/quintic_trajectory_generator_top_tb.sv
